[design/assert_macros.svh]
// Shared assertion macros for the setpoint controller checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ELSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("elsp check failed");

// Next-cycle implication, masked while reset is asserted.
`define ELSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("elsp check failed");

// Next-cycle implication that also holds across reset.
`define ELSP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("elsp check failed");

`endif

[design/elsp_pkg.sv]
package elsp_pkg;

    localparam int UNITS_CNT_W    = 3;
    localparam int CFG_ADDR_W     = 3;
    localparam int TRACK_TOL_MIN  = 200;
    localparam int CONFIRM_CYCLES = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_EXPORT_LIMIT  = 3'd0,
        REG_MAX_CHARGE    = 3'd1,
        REG_MAX_DISCHARGE = 3'd2,
        REG_DEADBAND      = 3'd3,
        REG_POWER_UNITS   = 3'd4,
        REG_RUN_UNITS     = 3'd5,
        REG_GRID_BOUND    = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CAUSE_NONE         = 2'd0,
        CAUSE_GRID_UNBOUND = 2'd1,
        CAUSE_GRID_INVALID = 2'd2,
        CAUSE_ALL_STOPPED  = 2'd3
    } cause_t;

    typedef enum logic {
        MODE_CONTROL = 1'b0,
        MODE_APPLY   = 1'b1
    } mode_t;

    // Per-word flags carried from the merge stage to the control stage
    typedef struct packed {
        mode_t  mode;
        cause_t cause;
        logic   any_valid;
        logic   err_gt_db;
    } s1_flags_t;

endpackage

[design/elsp_lane.sv]
module elsp_lane #(
    parameter int POWER_WIDTH = 24,
    parameter int LANE        = 0,
    parameter int ACC_W       = POWER_WIDTH + 4
) (
    input  logic signed [POWER_WIDTH-1:0]        unit_power,
    input  logic                                 power_valid,
    input  logic                                 running,
    input  logic [elsp_pkg::UNITS_CNT_W-1:0]     power_units,
    input  logic [elsp_pkg::UNITS_CNT_W-1:0]     run_units,
    output logic signed [ACC_W-1:0]              contrib,
    output logic                                 used,
    output logic                                 run_hit
);

    localparam logic [elsp_pkg::UNITS_CNT_W-1:0] LANE_IDX = elsp_pkg::UNITS_CNT_W'(LANE);

    // A unit counts only if it is bound and its reading is good
    assign used    = power_valid && (power_units > LANE_IDX);
    assign run_hit = running && (run_units > LANE_IDX);
    assign contrib = used ? ACC_W'(unit_power) : '0;

endmodule

[design/elsp_merge.sv]
module elsp_merge #(
    parameter int POWER_WIDTH = 24,
    parameter int NUM_UNITS   = 4,
    parameter int ACC_W       = POWER_WIDTH + 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    output logic                               out_valid,
    input  logic                               out_ready,
    input  elsp_pkg::mode_t                    mode,
    input  logic signed [POWER_WIDTH-1:0]      grid_meas,
    input  logic                               grid_ok,
    input  logic signed [POWER_WIDTH-1:0]      applied_setpoint,
    input  logic signed [ACC_W-1:0]            lane_contrib [NUM_UNITS],
    input  logic [NUM_UNITS-1:0]               lane_used,
    input  logic [NUM_UNITS-1:0]               lane_run,
    input  logic signed [POWER_WIDTH-1:0]      grid_target,
    input  logic [POWER_WIDTH-2:0]             deadband,
    input  logic                               grid_bound,
    input  logic [elsp_pkg::UNITS_CNT_W-1:0]   run_units,
    output elsp_pkg::s1_flags_t                flags,
    output logic signed [ACC_W-1:0]            sum,
    output logic signed [ACC_W-1:0]            sum_plus,
    output logic signed [ACC_W-1:0]            err_add,
    output logic signed [POWER_WIDTH-1:0]      applied
);

    logic                      valid_reg;
    logic                      valid_next;
    logic                      load;
    logic signed [ACC_W-1:0]   sum_c;
    logic signed [ACC_W-1:0]   err_c;
    logic signed [ACC_W-1:0]   abs_err;
    logic signed [ACC_W-1:0]   db_ext;
    logic                      err_ge_db;
    logic                      err_gt_db;
    logic                      run_fail;
    elsp_pkg::cause_t          cause_c;
    elsp_pkg::s1_flags_t       flags_reg;
    logic signed [ACC_W-1:0]   sum_reg;
    logic signed [ACC_W-1:0]   sum_plus_reg;
    logic signed [ACC_W-1:0]   err_add_reg;
    logic signed [POWER_WIDTH-1:0] applied_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;

    // Combine the lane contributions
    always_comb begin
        sum_c = '0;
        for (int i = 0; i < NUM_UNITS; i++) begin
            sum_c = sum_c + lane_contrib[i];
        end
    end

    assign err_c     = ACC_W'(grid_meas) - ACC_W'(grid_target);
    assign abs_err   = err_c[ACC_W-1] ? -err_c : err_c;
    assign db_ext    = $signed({{(ACC_W-POWER_WIDTH+1){1'b0}}, deadband});
    assign err_ge_db = abs_err >= db_ext;
    assign err_gt_db = abs_err > db_ext;
    assign run_fail  = (run_units != '0) && !(|lane_run);

    // Grid checks win over the run check
    always_comb begin
        if (!grid_bound) begin
            cause_c = elsp_pkg::CAUSE_GRID_UNBOUND;
        end else if (!grid_ok) begin
            cause_c = elsp_pkg::CAUSE_GRID_INVALID;
        end else if (run_fail) begin
            cause_c = elsp_pkg::CAUSE_ALL_STOPPED;
        end else begin
            cause_c = elsp_pkg::CAUSE_NONE;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            flags_reg.mode      <= mode;
            flags_reg.cause     <= cause_c;
            flags_reg.any_valid <= |lane_used;
            flags_reg.err_gt_db <= err_gt_db;
            sum_reg             <= sum_c;
            sum_plus_reg        <= err_ge_db ? (sum_c + err_c) : sum_c;
            err_add_reg         <= err_ge_db ? err_c : '0;
            applied_reg         <= applied_setpoint;
        end
    end

    assign flags    = flags_reg;
    assign sum      = sum_reg;
    assign sum_plus = sum_plus_reg;
    assign err_add  = err_add_reg;
    assign applied  = applied_reg;

endmodule

[design/elsp_ctrl.sv]
module elsp_ctrl #(
    parameter int POWER_WIDTH = 24,
    parameter int ACC_W       = POWER_WIDTH + 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  elsp_pkg::s1_flags_t                flags,
    input  logic signed [ACC_W-1:0]            sum,
    input  logic signed [ACC_W-1:0]            sum_plus,
    input  logic signed [ACC_W-1:0]            err_add,
    input  logic signed [POWER_WIDTH-1:0]      applied,
    input  logic [POWER_WIDTH-2:0]             charge_cap,
    input  logic [POWER_WIDTH-2:0]             discharge_cap,
    input  logic [POWER_WIDTH-2:0]             deadband,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [POWER_WIDTH-1:0]      target_power,
    output logic                               suppressed,
    output elsp_pkg::cause_t                   suppress_cause
);

    localparam logic signed [ACC_W-1:0] TOL_MIN = ACC_W'(elsp_pkg::TRACK_TOL_MIN);
    localparam logic [1:0] CONFIRM_N = 2'(elsp_pkg::CONFIRM_CYCLES);

    logic                          fire;
    logic                          m_valid_reg;
    logic signed [POWER_WIDTH-1:0] setpoint_reg;
    logic signed [POWER_WIDTH-1:0] setpoint_next;
    logic                          locked_reg;
    logic                          locked_next;
    logic [1:0]                    confirm_reg;
    logic [1:0]                    confirm_next;
    logic [1:0]                    confirm_inc;
    logic signed [POWER_WIDTH-1:0] target_reg;
    logic signed [POWER_WIDTH-1:0] target_next;
    logic                          supp_reg;
    logic                          supp_next;
    elsp_pkg::cause_t              cause_reg;

    logic signed [ACC_W-1:0] setpoint_ext;
    logic signed [ACC_W-1:0] held;
    logic signed [ACC_W-1:0] p_bess;
    logic signed [ACC_W-1:0] raw;
    logic signed [ACC_W-1:0] diff;
    logic signed [ACC_W-1:0] abs_diff;
    logic signed [ACC_W-1:0] db_ext;
    logic signed [ACC_W-1:0] tol;
    logic signed [ACC_W-1:0] lo_lim;
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] clamped;
    logic signed [ACC_W-1:0] abs_clamped;
    logic signed [ACC_W-1:0] new_sp;
    logic                    recalc;

    assign in_ready = !m_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    assign setpoint_ext = ACC_W'(setpoint_reg);
    assign held         = locked_reg ? setpoint_ext : '0;
    assign p_bess       = flags.any_valid ? sum : held;
    assign raw          = flags.any_valid ? sum_plus : (held + err_add);
    assign diff         = p_bess - setpoint_ext;
    assign abs_diff     = diff[ACC_W-1] ? -diff : diff;
    assign db_ext       = $signed({{(ACC_W-POWER_WIDTH+1){1'b0}}, deadband});
    assign tol          = (db_ext > TOL_MIN) ? db_ext : TOL_MIN;
    assign lo_lim       = -$signed({{(ACC_W-POWER_WIDTH+1){1'b0}}, charge_cap});
    assign hi_lim       = $signed({{(ACC_W-POWER_WIDTH+1){1'b0}}, discharge_cap});
    assign confirm_inc  = confirm_reg + 2'd1;

    // Clamp to the charge / discharge window, then zero small values
    always_comb begin
        clamped = raw;
        if (clamped < lo_lim) begin
            clamped = lo_lim;
        end
        if (clamped > hi_lim) begin
            clamped = hi_lim;
        end
        abs_clamped = clamped[ACC_W-1] ? -clamped : clamped;
        new_sp      = (abs_clamped < db_ext) ? '0 : clamped;
    end

    always_comb begin
        setpoint_next = setpoint_reg;
        locked_next   = locked_reg;
        confirm_next  = confirm_reg;
        recalc        = 1'b0;
        target_next   = setpoint_reg;
        supp_next     = 1'b0;
        if (flags.mode == elsp_pkg::MODE_APPLY) begin
            setpoint_next = applied;
            locked_next   = 1'b1;
            target_next   = applied;
        end else if (flags.cause != elsp_pkg::CAUSE_NONE) begin
            target_next = '0;
            supp_next   = 1'b1;
        end else begin
            recalc = !locked_reg;
            if (locked_reg) begin
                if (abs_diff > tol) begin
                    confirm_next = '0;
                end else if (flags.err_gt_db) begin
                    confirm_next = confirm_inc;
                    recalc       = confirm_inc >= CONFIRM_N;
                end else begin
                    confirm_next = '0;
                end
            end
            if (recalc) begin
                setpoint_next = new_sp[POWER_WIDTH-1:0];
                locked_next   = 1'b1;
                confirm_next  = '0;
            end
            target_next = setpoint_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            setpoint_reg <= '0;
            locked_reg   <= 1'b0;
            confirm_reg  <= '0;
        end else begin
            if (in_ready) begin
                m_valid_reg <= in_valid;
            end
            if (fire) begin
                setpoint_reg <= setpoint_next;
                locked_reg   <= locked_next;
                confirm_reg  <= confirm_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            target_reg <= target_next;
            supp_reg   <= supp_next;
            cause_reg  <= (flags.mode == elsp_pkg::MODE_APPLY) ? elsp_pkg::CAUSE_NONE
                                                                 : flags.cause;
        end
    end

    assign out_valid      = m_valid_reg;
    assign target_power   = target_reg;
    assign suppressed     = supp_reg;
    assign suppress_cause = cause_reg;

endmodule

[design/export_limit_battery_setpoint.sv]
// Export-limit battery setpoint controller.
// Input stream: one word per control cycle. s_tuser carries the mode: control
// cycle, or apply an externally issued setpoint. s_tdata carries the grid
// reading, the battery unit readings with their valid and running masks, and
// the applied setpoint. Output stream: one word per input word with the
// locked battery setpoint, a suppress flag and its cause.
// Configuration: write cfg_wdata to register cfg_addr while cfg_wen is high;
// registers must be written by the user only while no word is in flight; the
// block does not enforce this. Pipeline: the merge stage registers each taken
// word, then the control stage loads the output register.
// Throughput: one word per cycle while m_tready is high; the locked setpoint
// is updated in the control stage as each word is taken, so each word sees
// the state left by the one before. Reset: all configuration registers clear
// to zero, the setpoint is unlocked and both pipeline stages empty.
// Stall: when m_tready is low the output word holds; the merge stage still
// takes one more word, and s_tready drops only when both stages are full.
module export_limit_battery_setpoint #(
    parameter int NUM_UNITS   = 4,
    parameter int POWER_WIDTH = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wen,
    input  logic [elsp_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [POWER_WIDTH-1:0]                cfg_wdata,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata, low to high: grid_power, grid_ok, unit_power_0..N-1,
    // power_valid_mask, running_mask, applied_setpoint, zero padding
    input  logic [((POWER_WIDTH*(NUM_UNITS+2)+1+2*NUM_UNITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: mode
    input  logic                                  s_tuser,
    // output stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata, low to high: target_power, suppressed, suppress_cause, zero padding
    output logic [((POWER_WIDTH+3+7)/8)*8-1:0]    m_tdata
);

    localparam int ACC_W       = POWER_WIDTH + 4;
    localparam int OK_BIT      = POWER_WIDTH;
    localparam int UNIT_LSB    = POWER_WIDTH + 1;
    localparam int PVM_LSB     = UNIT_LSB + NUM_UNITS * POWER_WIDTH;
    localparam int RUN_LSB     = PVM_LSB + NUM_UNITS;
    localparam int APPLIED_LSB = RUN_LSB + NUM_UNITS;

    // configuration registers
    logic signed [POWER_WIDTH-1:0]          grid_target_reg;
    logic [POWER_WIDTH-2:0]                 charge_cap_reg;
    logic [POWER_WIDTH-2:0]                 discharge_cap_reg;
    logic [POWER_WIDTH-2:0]                 deadband_reg;
    logic [elsp_pkg::UNITS_CNT_W-1:0]       power_units_reg;
    logic [elsp_pkg::UNITS_CNT_W-1:0]       run_units_reg;
    logic                                   grid_bound_reg;

    // unpacked input word
    logic signed [POWER_WIDTH-1:0]          grid_meas;
    logic                                   grid_ok;
    logic [NUM_UNITS-1:0]                   power_valid_mask;
    logic [NUM_UNITS-1:0]                   running_mask;
    logic signed [POWER_WIDTH-1:0]          applied_setpoint;

    // lane results
    logic signed [ACC_W-1:0]                lane_contrib [NUM_UNITS];
    logic [NUM_UNITS-1:0]                   lane_used;
    logic [NUM_UNITS-1:0]                   lane_run;

    // merge stage to control stage
    logic                                   s1_valid;
    logic                                   s1_ready;
    elsp_pkg::s1_flags_t                    s1_flags;
    logic signed [ACC_W-1:0]                s1_sum;
    logic signed [ACC_W-1:0]                s1_sum_plus;
    logic signed [ACC_W-1:0]                s1_err_add;
    logic signed [POWER_WIDTH-1:0]          s1_applied;

    logic signed [POWER_WIDTH-1:0]          target_power;
    logic                                   suppressed;
    elsp_pkg::cause_t                       suppress_cause;

    // Take configuration writes; an index past the list is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_target_reg   <= '0;
            charge_cap_reg    <= '0;
            discharge_cap_reg <= '0;
            deadband_reg      <= '0;
            power_units_reg   <= '0;
            run_units_reg     <= '0;
            grid_bound_reg    <= 1'b0;
        end else if (cfg_wen) begin
            case (elsp_pkg::cfg_reg_t'(cfg_addr))
                elsp_pkg::REG_EXPORT_LIMIT: begin
                    grid_target_reg <= cfg_wdata;
                end
                elsp_pkg::REG_MAX_CHARGE: begin
                    charge_cap_reg <= cfg_wdata[POWER_WIDTH-2:0];
                end
                elsp_pkg::REG_MAX_DISCHARGE: begin
                    discharge_cap_reg <= cfg_wdata[POWER_WIDTH-2:0];
                end
                elsp_pkg::REG_DEADBAND: begin
                    deadband_reg <= cfg_wdata[POWER_WIDTH-2:0];
                end
                elsp_pkg::REG_POWER_UNITS: begin
                    power_units_reg <= cfg_wdata[elsp_pkg::UNITS_CNT_W-1:0];
                end
                elsp_pkg::REG_RUN_UNITS: begin
                    run_units_reg <= cfg_wdata[elsp_pkg::UNITS_CNT_W-1:0];
                end
                elsp_pkg::REG_GRID_BOUND: begin
                    grid_bound_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Unpack the input word
    assign grid_meas        = s_tdata[POWER_WIDTH-1:0];
    assign grid_ok          = s_tdata[OK_BIT];
    assign power_valid_mask = s_tdata[PVM_LSB +: NUM_UNITS];
    assign running_mask     = s_tdata[RUN_LSB +: NUM_UNITS];
    assign applied_setpoint = s_tdata[APPLIED_LSB +: POWER_WIDTH];

    // One lane per battery unit: bound check and gating of its reading
    for (genvar i = 0; i < NUM_UNITS; i++) begin : g_lane
        elsp_lane #(
            .POWER_WIDTH (POWER_WIDTH),
            .LANE        (i),
            .ACC_W       (ACC_W)
        ) u_lane (
            .unit_power  (s_tdata[UNIT_LSB + i*POWER_WIDTH +: POWER_WIDTH]),
            .power_valid (power_valid_mask[i]),
            .running     (running_mask[i]),
            .power_units (power_units_reg),
            .run_units   (run_units_reg),
            .contrib     (lane_contrib[i]),
            .used        (lane_used[i]),
            .run_hit     (lane_run[i])
        );
    end

    // Merge stage: sum the lanes, form the grid error and the suppress cause
    elsp_merge #(
        .POWER_WIDTH (POWER_WIDTH),
        .NUM_UNITS   (NUM_UNITS),
        .ACC_W       (ACC_W)
    ) u_merge (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .out_valid        (s1_valid),
        .out_ready        (s1_ready),
        .mode             (elsp_pkg::mode_t'(s_tuser)),
        .grid_meas        (grid_meas),
        .grid_ok          (grid_ok),
        .applied_setpoint (applied_setpoint),
        .lane_contrib     (lane_contrib),
        .lane_used        (lane_used),
        .lane_run         (lane_run),
        .grid_target      (grid_target_reg),
        .deadband         (deadband_reg),
        .grid_bound       (grid_bound_reg),
        .run_units        (run_units_reg),
        .flags            (s1_flags),
        .sum              (s1_sum),
        .sum_plus         (s1_sum_plus),
        .err_add          (s1_err_add),
        .applied          (s1_applied)
    );

    // Control stage: hold the locked setpoint, confirm count and output word
    elsp_ctrl #(
        .POWER_WIDTH (POWER_WIDTH),
        .ACC_W       (ACC_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s1_valid),
        .in_ready       (s1_ready),
        .flags          (s1_flags),
        .sum            (s1_sum),
        .sum_plus       (s1_sum_plus),
        .err_add        (s1_err_add),
        .applied        (s1_applied),
        .charge_cap     (charge_cap_reg),
        .discharge_cap  (discharge_cap_reg),
        .deadband       (deadband_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .target_power   (target_power),
        .suppressed     (suppressed),
        .suppress_cause (suppress_cause)
    );

    // Pack the output word, padding stays zero
    always_comb begin
        m_tdata                       = '0;
        m_tdata[POWER_WIDTH-1:0]      = target_power;
        m_tdata[POWER_WIDTH]          = suppressed;
        m_tdata[POWER_WIDTH+1 +: 2]   = suppress_cause;
    end

endmodule

[design/elsp_checker.sv]
`include "assert_macros.svh"

module elsp_checker #(
    parameter int POWER_WIDTH = 24,
    parameter int OUT_W       = 32
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic                   supp;
    logic [1:0]             cause;
    logic [POWER_WIDTH-1:0] target;
    logic                   stalled;

    assign target  = m_tdata[POWER_WIDTH-1:0];
    assign supp    = m_tdata[POWER_WIDTH];
    assign cause   = m_tdata[POWER_WIDTH+1 +: 2];
    assign stalled = m_tvalid && !m_tready;

    // A suppressed word carries a zero setpoint
    `ELSP_ASSERT_SAME(a_supp_zero, aclk, aresetn, m_tvalid && supp, target == '0)

    // The suppress flag and the cause agree
    `ELSP_ASSERT_SAME(a_supp_cause, aclk, aresetn, m_tvalid, supp == (cause != elsp_pkg::CAUSE_NONE))

    // A stalled output word holds
    `ELSP_ASSERT_NEXT(a_out_hold, aclk, aresetn, stalled, m_tvalid && $stable(m_tdata))

    // Reset empties the output stage
    `ELSP_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind export_limit_battery_setpoint elsp_checker #(
    .POWER_WIDTH (POWER_WIDTH),
    .OUT_W       (((POWER_WIDTH+3+7)/8)*8)
) u_elsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/setpoint_checker.sv]
`timescale 1ns / 100ps

module setpoint_checker #(
    parameter int NUM_UNITS   = 4,
    parameter int POWER_WIDTH = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wen,
    input  logic [elsp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [POWER_WIDTH-1:0] cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // s_tdata, low to high: grid_power, grid_ok, unit_power_0..N-1,
    // power_valid_mask, running_mask, applied_setpoint, zero padding
    input  logic [((POWER_WIDTH*(NUM_UNITS+2)+1+2*NUM_UNITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: mode
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata, low to high: target_power, suppressed, suppress_cause, zero padding
    input  logic [((POWER_WIDTH+3+7)/8)*8-1:0] m_tdata,
    output int                     mismatch_count,
    output int                     words_pending,
    output logic signed [POWER_WIDTH-1:0] setpoint_hint
);
    import elsp_pkg::*;

    localparam int PW          = POWER_WIDTH;
    localparam int NU          = NUM_UNITS;
    localparam int DATA_W      = ((PW*(NU+2)+1+2*NU+7)/8)*8;
    localparam int UNIT_LSB    = PW + 1;
    localparam int VALID_LSB   = UNIT_LSB + PW*NU;
    localparam int RUN_LSB     = VALID_LSB + NU;
    localparam int APPLIED_LSB = RUN_LSB + NU;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic signed [PW-1:0] target;
        logic                 suppressed;
        cause_t               cause;
    } setpoint_word_t;

    setpoint_word_t expected_words [$];

    // register copy
    logic signed [PW-1:0]   limit_w;
    logic [PW-2:0]          charge_max;
    logic [PW-2:0]          discharge_max;
    logic [PW-2:0]          band;
    logic [UNITS_CNT_W-1:0] power_cnt;
    logic [UNITS_CNT_W-1:0] run_cnt;
    logic                   grid_bound;

    // controller state
    logic signed [PW-1:0]   held_setpoint;
    logic                   setpoint_held;
    logic [1:0]             confirm_run;

    int faults;
    int words_checked;

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the controller state by one word and return the result it causes.
    function automatic setpoint_word_t next_setpoint(mode_t mode, logic [DATA_W-1:0] d);
        setpoint_word_t r;
        longint grid, bess, sum, err, tol, raw, db;
        int     n;
        bit     any_valid, running, recalc;
        r.target     = '0;
        r.suppressed = 1'b0;
        r.cause      = CAUSE_NONE;
        if (mode == MODE_APPLY) begin
            held_setpoint = d[APPLIED_LSB +: PW];
            setpoint_held = 1'b1;
            r.target = held_setpoint;
            return r;
        end
        r.suppressed = 1'b1;
        if (!grid_bound) begin
            r.cause = CAUSE_GRID_UNBOUND;
            return r;
        end
        if (!d[PW]) begin
            r.cause = CAUSE_GRID_INVALID;
            return r;
        end
        grid = $signed(d[PW-1:0]);

        // battery power: sum of valid bound readings, else the held setpoint
        bess = setpoint_held ? longint'(held_setpoint) : 0;
        n = (power_cnt > NU) ? NU : power_cnt;
        sum = 0;
        any_valid = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (d[VALID_LSB + i]) begin
                sum += $signed(d[UNIT_LSB + PW*i +: PW]);
                any_valid = 1'b1;
            end
        end
        if (any_valid)
            bess = sum;

        n = (run_cnt > NU) ? NU : run_cnt;
        running = (n == 0);
        for (int i = 0; i < n; i++)
            if (d[RUN_LSB + i])
                running = 1'b1;
        if (!running) begin
            r.cause = CAUSE_ALL_STOPPED;
            return r;
        end
        r.suppressed = 1'b0;
        r.cause      = CAUSE_NONE;

        db  = band;
        err = grid - longint'(limit_w);
        tol = (db > TRACK_TOL_MIN) ? db : TRACK_TOL_MIN;

        recalc = !setpoint_held;
        if (!recalc) begin
            if (magnitude(bess - longint'(held_setpoint)) > tol) begin
                confirm_run = '0;
            end else if (magnitude(err) > db) begin
                confirm_run = confirm_run + 2'd1;
                if (confirm_run >= CONFIRM_CYCLES)
                    recalc = 1'b1;
            end else begin
                confirm_run = '0;
            end
        end

        if (recalc) begin
            raw = bess;
            if (magnitude(err) >= db)
                raw += err;
            if (raw < -longint'(charge_max))
                raw = -longint'(charge_max);
            if (raw > longint'(discharge_max))
                raw = discharge_max;
            if (magnitude(raw) < db)
                raw = 0;
            held_setpoint = raw[PW-1:0];
            setpoint_held = 1'b1;
            confirm_run   = '0;
        end
        r.target = held_setpoint;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        setpoint_word_t want;
        if (!aresetn) begin
            limit_w       = '0;
            charge_max    = '0;
            discharge_max = '0;
            band          = '0;
            power_cnt     = '0;
            run_cnt       = '0;
            grid_bound    = 1'b0;
            held_setpoint = '0;
            setpoint_held = 1'b0;
            confirm_run   = '0;
            faults        = 0;
            words_checked = 0;
            expected_words.delete();
        end else begin
            if (cfg_wen) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_EXPORT_LIMIT:  limit_w       = cfg_wdata;
                    REG_MAX_CHARGE:    charge_max    = cfg_wdata[PW-2:0];
                    REG_MAX_DISCHARGE: discharge_max = cfg_wdata[PW-2:0];
                    REG_DEADBAND:      band          = cfg_wdata[PW-2:0];
                    REG_POWER_UNITS:   power_cnt     = cfg_wdata[UNITS_CNT_W-1:0];
                    REG_RUN_UNITS:     run_cnt       = cfg_wdata[UNITS_CNT_W-1:0];
                    REG_GRID_BOUND:    grid_bound    = cfg_wdata[0];
                    default: ;
                endcase
            end
            // compare before queuing: the output lags the input by the merge and control stage registers
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    if (faults < REPORT_MAX)
                        $display("word %0d: unexpected result, got target %0d flag %0b cause %0d",
                                 words_checked, $signed(m_tdata[PW-1:0]), m_tdata[PW],
                                 m_tdata[PW+2:PW+1]);
                    faults++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_tdata[PW-1:0] !== want.target || m_tdata[PW] !== want.suppressed ||
                        m_tdata[PW+2:PW+1] !== want.cause) begin
                        if (faults < REPORT_MAX)
                            $display({"word %0d: expected target %0d flag %0b cause %0d, ",
                                      "got target %0d flag %0b cause %0d"},
                                     words_checked, want.target, want.suppressed, want.cause,
                                     $signed(m_tdata[PW-1:0]), m_tdata[PW],
                                     m_tdata[PW+2:PW+1]);
                        faults++;
                    end
                end
                words_checked++;
            end
            if (s_tvalid && s_tready)
                expected_words.insert(expected_words.size(),
                                      next_setpoint(mode_t'(s_tuser), s_tdata));
        end
        mismatch_count <= faults;
        words_pending  <= expected_words.size();
        setpoint_hint  <= held_setpoint;
    end

endmodule

[tb/export_limit_battery_setpoint_tb.sv]
`timescale 1ns / 100ps

module export_limit_battery_setpoint_tb;
    import elsp_pkg::*;

    localparam int NU          = 4;
    localparam int PW          = 24;
    localparam int DATA_W      = ((PW*(NU+2)+1+2*NU+7)/8)*8;
    localparam int OUT_W       = ((PW+3+7)/8)*8;
    localparam int PAD_W       = DATA_W - (PW*(NU+2)+1+2*NU);
    localparam int QUIET_LIMIT = 2000;
    localparam logic signed [PW-1:0] P_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] P_MIN = {1'b1, {(PW-1){1'b0}}};

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wen   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [PW-1:0]     cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    // s_tdata, low to high: grid_power, grid_ok, unit_power_0..3,
    // power_valid_mask, running_mask, applied_setpoint, zero padding
    logic [DATA_W-1:0] s_tdata   = '0;
    // s_tuser: mode
    logic              s_tuser   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    // m_tdata, low to high: target_power, suppressed, suppress_cause, zero padding
    logic [OUT_W-1:0]  m_tdata;

    int                mismatch_count;
    int                words_pending;
    logic signed [PW-1:0] setpoint_hint;

    // stimulus-side copy of the active limits, used only to shape the words
    int limit_now = 0;
    int band_now  = 0;
    int power_now = 0;

    logic stall_on    = 1'b0;
    int   ready_left  = 0;
    int   quiet_cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    export_limit_battery_setpoint #(
        .NUM_UNITS  (NU),
        .POWER_WIDTH(PW)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    setpoint_checker #(
        .NUM_UNITS  (NU),
        .POWER_WIDTH(PW)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatch_count(mismatch_count),
        .words_pending (words_pending),
        .setpoint_hint (setpoint_hint)
    );

    // Receiver: drop m_tready at random and hold it high otherwise; keep it
    // high for good once stalls are switched off.
    always @(posedge aclk) begin
        if (!stall_on) begin
            m_tready <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (m_tready && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            ready_left <= $urandom_range(0, 11);
        end else begin
            m_tready   <= 1'b1;
            ready_left <= $urandom_range(0, 15);
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wen || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Saturate a wide value into the power range.
    function automatic logic signed [PW-1:0] fit24(longint v);
        if (v > longint'(P_MAX))
            return P_MAX;
        if (v < longint'(P_MIN))
            return P_MIN;
        return v[PW-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] pack_word(
        logic [PW-1:0] grid, logic ok,
        logic [PW-1:0] u0, logic [PW-1:0] u1, logic [PW-1:0] u2, logic [PW-1:0] u3,
        logic [NU-1:0] valid_mask, logic [NU-1:0] run_mask, logic [PW-1:0] applied);
        return {{PAD_W{1'b0}}, applied, run_mask, valid_mask, u3, u2, u1, u0, ok, grid};
    endfunction

    // Present one word and hold it until the block takes it.
    task automatic push_word(mode_t mode, logic [DATA_W-1:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // Stop sending and wait until every expected result has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all seven registers in index order while the block is idle.
    task automatic load_limits(logic [PW-1:0] lim, logic [PW-1:0] chg, logic [PW-1:0] dis,
                               logic [PW-1:0] db, logic [PW-1:0] pu, logic [PW-1:0] ru,
                               logic [PW-1:0] gb);
        logic [PW-1:0] vals [7];
        vals = '{lim, chg, dis, db, pu, ru, gb};
        settle();
        for (int i = 0; i < 7; i++) begin
            cfg_wen   <= 1'b1;
            cfg_addr  <= cfg_reg_t'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wen   <= 1'b0;
        limit_now = $signed(lim);
        band_now  = db[PW-2:0];
        power_now = (pu[2:0] > NU) ? NU : pu[2:0];
    endtask

    // Random words. Most control words track the held setpoint so the
    // confirm count and the recalculation get exercised; the rest is noise.
    task automatic send_batch(int count, logic idle);
        logic signed [PW-1:0] unit_w [NU];
        logic signed [PW-1:0] grid_w, applied_w;
        logic [NU-1:0]        valid_w, run_w;
        longint               rest;
        int                   k, span;
        stall_on <= idle;
        for (int j = 0; j < count; j++) begin
            applied_w = $urandom;
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    applied_w = int'($urandom_range(0, 20000)) - 10000;
                push_word(MODE_APPLY, pack_word($urandom, $urandom, $urandom, $urandom,
                                                $urandom, $urandom, $urandom, $urandom,
                                                applied_w));
            end else begin
                for (int i = 0; i < NU; i++)
                    unit_w[i] = $urandom;
                valid_w = $urandom;
                run_w   = ($urandom_range(0, 6) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
                // grid: inside the deadband, just outside it, or anywhere
                case ($urandom_range(0, 3))
                    0: begin
                        span   = (band_now > 100000) ? 100000 : band_now;
                        grid_w = fit24(longint'(limit_now) +
                                       int'($urandom_range(0, 2*span)) - span);
                    end
                    3: grid_w = $urandom;
                    default: begin
                        span   = band_now + $urandom_range(1, 5000);
                        grid_w = fit24($urandom_range(0, 1) ? longint'(limit_now) + span
                                                             : longint'(limit_now) - span);
                    end
                endcase
                if ($urandom_range(0, 9) < 7) begin
                    // make the valid bound readings add up close to the setpoint
                    k = -1;
                    for (int i = power_now - 1; i >= 0; i--)
                        if (valid_w[i])
                            k = i;
                    if (k >= 0) begin
                        rest = longint'(setpoint_hint) + int'($urandom_range(0, 500)) - 250;
                        for (int i = 0; i < power_now; i++) begin
                            if (valid_w[i] && i != k) begin
                                unit_w[i] = int'($urandom_range(0, 4000)) - 2000;
                                rest -= unit_w[i];
                            end
                        end
                        unit_w[k] = fit24(rest);
                    end
                end
                push_word(MODE_CONTROL, pack_word(grid_w, $urandom_range(0, 15) != 0,
                                                  unit_w[0], unit_w[1], unit_w[2], unit_w[3],
                                                  valid_w, run_w, applied_w));
            end
            if (idle && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    endtask

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn  <= 1'b1;
        stall_on <= 1'b1;

        // Registers still at reset: grid unbound, state must not move.
        push_word(MODE_CONTROL, pack_word(1234, 1, 0, 0, 0, 0, 4'h0, 4'hF, 0));

        load_limits(0, 5000, 4000, 100, 4, 4, 1);
        // grid reading invalid, then every unit stopped
        push_word(MODE_CONTROL, pack_word(1234, 0, 0, 0, 0, 0, 4'hF, 4'hF, 0));
        push_word(MODE_CONTROL, pack_word(1234, 1, 0, 0, 0, 0, 4'hF, 4'h0, 0));
        // first cycle locks at once; error equal to the deadband still counts
        push_word(MODE_CONTROL, pack_word(100, 1, 0, 0, 0, 0, 4'h0, 4'hF, 0));
        // tracking and outside the deadband twice: recalculate
        repeat (2) push_word(MODE_CONTROL, pack_word(1000, 1, 25, 25, 25, 25, 4'hF, 4'hF, 0));
        // inside the deadband, then not tracking: confirm count clears
        push_word(MODE_CONTROL, pack_word(50, 1, 275, 275, 275, 275, 4'hF, 4'hF, 0));
        push_word(MODE_CONTROL, pack_word(2000, 1, 0, 0, 0, 0, 4'hF, 4'hF, 0));
        // grid extremes drive the clamp to both limits
        repeat (2) push_word(MODE_CONTROL, pack_word(P_MAX, 1, 275, 275, 275, 275,
                                                     4'hF, 4'hF, 0));
        repeat (2) push_word(MODE_CONTROL, pack_word(P_MIN, 1, 1000, 1000, 1000, 1000,
                                                     4'hF, 4'hF, 0));
        // applied setpoints at both extremes (other fields all ones, then all zeros), then a small one
        push_word(MODE_APPLY, pack_word('1, 1, '1, '1, '1, '1, 4'hF, 4'hF, P_MIN));
        push_word(MODE_APPLY, pack_word(0, 0, 0, 0, 0, 0, 4'h0, 4'h0, P_MAX));
        push_word(MODE_APPLY, pack_word(0, 1, 0, 0, 0, 0, 4'h0, 4'hF, 50));
        // unit reading extremes with a partial valid mask
        push_word(MODE_CONTROL, pack_word(0, 1, P_MAX, P_MIN, P_MAX, P_MIN,
                                          4'b0101, 4'hF, 0));
        // no valid reading: battery power falls back to the held setpoint
        repeat (2) push_word(MODE_CONTROL, pack_word(500, 1, 0, 0, 0, 0, 4'h0, 4'hF, 0));
        // only the last unit running still passes the run check
        push_word(MODE_CONTROL, pack_word(600, 1, 0, 0, 0, 0, 4'h0, 4'b1000, 0));
        // small recalculated value is zeroed
        push_word(MODE_APPLY, pack_word(0, 1, 0, 0, 0, 0, 4'h0, 4'hF, 0));
        repeat (2) push_word(MODE_CONTROL, pack_word(150, 1, -120, 0, 0, 0,
                                                     4'b0001, 4'hF, 0));

        // Random phases, each under its own register setting.
        load_limits(0, 5000, 4000, 100, 4, 4, 1);
        send_batch(60, 1);
        load_limits(P_MIN, P_MAX, P_MAX, 0, 7, 0, 1);
        send_batch(50, 1);
        load_limits(P_MAX, 0, 0, P_MAX, 0, 7, 1);
        send_batch(40, 1);
        load_limits(int'($urandom_range(0, 40000)) - 20000, $urandom,
                    $urandom_range(0, 50000), $urandom_range(0, 400),
                    {21'($urandom), 3'($urandom_range(1, 3))},
                    {21'($urandom), 3'($urandom_range(1, 3))},
                    {23'($urandom), 1'b1});
        send_batch(60, 1);
        load_limits($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    {23'($urandom), 1'b0});
        send_batch(20, 1);
        load_limits(-1000, 10000, 10000, 300, 2, 5, 24'hFFFFFF);
        send_batch(60, 1);
        load_limits($urandom, $urandom_range(0, 100000), $urandom_range(0, 100000),
                    $urandom_range(0, 1000), $urandom_range(0, 7), $urandom_range(0, 7), 1);
        send_batch(60, 1);
        // last stretch at full rate on both sides
        load_limits(500, 3000, 3000, 50, 4, 4, 1);
        send_batch(50, 0);

        settle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
